/* rtl/core/cle_pkg.sv */
`default_nettype none

package cle_pkg;

    // Line store geometry
    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    // A line holds at most LINE_DEPTH-1 bytes, so the count fits the address width
    localparam int CNT_W      = ADDR_W;
    localparam int LEN_W      = 5;

    // Terminal characters
    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_BEL = 8'd7;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DEL = 8'd127;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // One result transaction
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data_byte;
        logic [LEN_W-1:0]  line_length;
        logic              last;
    } result_t;

    // Line count masked to the length field
    function automatic logic [LEN_W-1:0] len_field(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cle_line_ram.sv */
`default_nettype none

module cle_line_ram (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [cle_pkg::ADDR_W-1:0] waddr,
    input  wire logic [7:0]                 wdata,
    input  wire logic                       re,
    input  wire logic [cle_pkg::ADDR_W-1:0] raddr,
    output logic      [7:0]                 rdata
);
    import cle_pkg::*;

    logic [7:0] mem [LINE_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cle_ctrl.sv */
`default_nettype none

module cle_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_data,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [7:0]                 rx_byte,
    // result toward the output register
    output logic                            res_valid,
    input  wire logic                       res_take,
    output cle_pkg::result_t                res,
    // line store ports
    output logic                            ram_we,
    output logic      [cle_pkg::ADDR_W-1:0] ram_waddr,
    output logic      [7:0]                 ram_wdata,
    output logic                            ram_re,
    output logic      [cle_pkg::ADDR_W-1:0] ram_raddr,
    input  wire logic [7:0]                 ram_rdata
);
    import cle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_RDREQ,
        S_RDOUT,
        S_END
    } state_t;

    typedef enum logic [1:0] {
        OP_CR,
        OP_ERASE,
        OP_STORE,
        OP_FULL
    } op_t;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [7:0]       char_reg, char_next;
    logic [1:0]       echo_idx_reg, echo_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             echo_enable_reg, echo_enable_next;

    logic             accept;
    logic             is_cr, is_erase, is_ign, fits;
    logic             echo_last;
    logic             fire;
    logic [7:0]       echo_byte;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign fire     = res_valid && res_take;

    // Input byte decode
    assign is_cr    = (rx_byte == CH_CR);
    assign is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    assign is_ign   = (rx_byte == CH_LF) || (rx_byte == CH_NUL);
    assign fits     = ((CNT_W + 1)'(count_reg) + (CNT_W + 1)'(1))
                      < (CNT_W + 1)'(LINE_DEPTH);

    // Echo script per operation
    always_comb
    begin
        echo_byte = char_reg;
        echo_last = 1'b1;
        case (op_reg)
            OP_CR:
            begin
                echo_byte = (echo_idx_reg == 2'd0) ? CH_CR : CH_LF;
                echo_last = 1'b0;
            end
            OP_ERASE:
            begin
                echo_byte = (echo_idx_reg == 2'd1) ? CH_SP : CH_BS;
                echo_last = (echo_idx_reg == 2'd2);
            end
            OP_STORE:
            begin
                echo_byte = char_reg;
            end
            OP_FULL:
            begin
                echo_byte = CH_BEL;
            end
            default:
            begin
                echo_byte = char_reg;
            end
        endcase
    end

    // Result selection
    always_comb
    begin
        res_valid       = 1'b0;
        res.kind        = KIND_ECHO;
        res.data_byte   = 8'd0;
        res.line_length = '0;
        res.last        = 1'b0;
        case (state_reg)
            S_ECHO:
            begin
                res_valid     = 1'b1;
                res.data_byte = echo_byte;
                res.last      = echo_last;
            end
            S_RDOUT:
            begin
                res_valid     = 1'b1;
                res.kind      = KIND_LINE;
                res.data_byte = ram_rdata;
            end
            S_END:
            begin
                res_valid       = 1'b1;
                res.kind        = KIND_END;
                res.line_length = len_field(count_reg);
                res.last        = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Line store access: writes only on accept, reads only in readout
    assign ram_we    = accept && !is_cr && !is_erase && !is_ign && fits;
    assign ram_waddr = count_reg;
    assign ram_wdata = rx_byte;
    assign ram_re    = (state_reg == S_RDREQ);
    assign ram_raddr = rd_idx_reg;

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        char_next        = char_reg;
        echo_idx_next    = echo_idx_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        echo_enable_next = cfg_write ? cfg_data : echo_enable_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    char_next     = rx_byte;
                    echo_idx_next = 2'd0;
                    rd_idx_next   = '0;
                    if (is_cr)
                    begin
                        op_next = OP_CR;
                        if (echo_enable_reg)
                        begin
                            state_next = S_ECHO;
                        end
                        else if (count_reg != '0)
                        begin
                            state_next = S_RDREQ;
                        end
                        else
                        begin
                            state_next = S_END;
                        end
                    end
                    else if (is_erase)
                    begin
                        op_next = OP_ERASE;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            if (echo_enable_reg)
                            begin
                                state_next = S_ECHO;
                            end
                        end
                    end
                    else if (!is_ign)
                    begin
                        if (fits)
                        begin
                            op_next    = OP_STORE;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            op_next = OP_FULL;
                        end
                        if (echo_enable_reg)
                        begin
                            state_next = S_ECHO;
                        end
                    end
                end
            end
            S_ECHO:
            begin
                if (fire)
                begin
                    echo_idx_next = echo_idx_reg + 2'd1;
                    if (echo_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (op_reg == OP_CR && echo_idx_reg == 2'd1)
                    begin
                        state_next = (count_reg != '0) ? S_RDREQ : S_END;
                    end
                end
            end
            S_RDREQ:
            begin
                state_next = S_RDOUT;
            end
            S_RDOUT:
            begin
                if (fire)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    if (rd_idx_reg == count_reg - CNT_W'(1))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_RDREQ;
                    end
                end
            end
            S_END:
            begin
                if (fire)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_STORE;
            char_reg        <= 8'd0;
            echo_idx_reg    <= 2'd0;
            count_reg       <= '0;
            rd_idx_reg      <= '0;
            echo_enable_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            char_reg        <= char_next;
            echo_idx_reg    <= echo_idx_next;
            count_reg       <= count_next;
            rd_idx_reg      <= rd_idx_next;
            echo_enable_reg <= echo_enable_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/console_line_editor.sv */
// Console line editor.
// Input channel: in_valid / in_stall with rx_byte, one received terminal byte per
// transaction. Output channel: out_valid / out_stall with kind, data_byte,
// line_length and last; last marks the final result of an input byte.
// Configuration: cfg_write strobes cfg_data into the echo enable register.
// Other bytes are written to a line RAM (one write, one read port) while the line
// has room; CR reads the line back out, BS/DEL drop the last byte, LF and NUL are ignored.
// Timing: a byte is accepted only while the editor is idle; the editor then stays
// busy until its echo results are taken, and a CR also reads the line back: each
// line byte costs a RAM read request state and a data state because the RAM
// read port is registered.
// The first result is decoded from the registered controller state.
// Results pass through an output register: a stalled result holds, and the
// editor waits on it but still accepts a new byte once idle.
// Reset clears the line count, the echo enable and the output valid; the
// line RAM is not cleared since only bytes below the count are ever read.
`default_nettype none

module console_line_editor (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [7:0]                 rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [1:0]                 kind,
    output logic      [7:0]                 data_byte,
    output logic      [cle_pkg::LEN_W-1:0]  line_length,
    output logic                            last
);
    import cle_pkg::*;

    result_t           res;
    result_t           out_reg;
    logic              out_valid_reg;
    logic              res_valid;
    logic              res_take;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    // Output register may load when empty or being taken this cycle
    assign res_take = !out_valid_reg || !out_stall;

    cle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cle_line_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign data_byte   = out_reg.data_byte;
    assign line_length = out_reg.line_length;
    assign last        = out_reg.last;

endmodule

`default_nettype wire
